FILE: hdl/wpfs_pkg.sv
// shared types, constants and the cordic arctangent table for the
// weighted point fourier sum; no dependencies
`default_nettype none

package wpfs_pkg;

  // sizing
  localparam int TRIG_BITS = 16;
  localparam int ACC_BITS  = 48;
  localparam int OUT_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 24;
  localparam int WGT_W     = 16;

  // shared multiplier, signed 33 x 33
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // cordic working widths
  localparam int XW        = TRIG_BITS + 3;
  localparam int ITER_W    = $clog2(TRIG_BITS);
  localparam int ATAN_IDX_W = 5;
  localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
  localparam logic [63:0] CORDIC_X0 =
    (GAIN_Q32 + (64'd1 << (32 - TRIG_BITS))) >> (33 - TRIG_BITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SCALE = 2'd3;
  localparam logic [CFG_W-1:0]     NORM_RESET     = 32'd65536;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_X,
    MUL_Y,
    MUL_Z,
    MUL_WC,
    MUL_WS,
    MUL_CHI,
    MUL_CLO,
    MUL_SHI,
    MUL_SLO
  } mul_sel_t;

  typedef struct packed {
    logic              load_in;
    mul_sel_t          mul_sel;
    logic              phase_load;
    logic              phase_add;
    logic              cordic_init;
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              trig_fix;
    logic              acc_cos;
    logic              acc_sin;
    logic              hold_hi;
    logic              re_set;
    logic              im_set;
    logic              out_load;
  } wpfs_cmd_t;

  typedef struct packed {
    logic out_free;
  } wpfs_stat_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/weighted_point_fourier_sum.sv
// top level of the weighted point fourier sum
// depends on wpfs_pkg, wpfs_ctrl and wpfs_datapath
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+--------------------------------------
//  in      | input     | in_valid/in_stall | pos_x/y/z, point_weight, flags
//  out     | output    | out_valid/stall   | real_part, imag_part
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// an accepted point is captured, then goes through the dot product on
// the shared multiplier, sixteen cordic iterations (one per cycle), the
// trig clamp and the two weight products and accumulates
// a skipped point is only captured; a last point adds normalization
// (four multiplies on the same multiplier) before its word
// rst_n is synchronous; it restores the sequencer and config registers,
// clears both sums and empties the output register
// a stalled result word is held in the output register while the next
// point is taken; a further result waits until that word is gone
`default_nettype none

module weighted_point_fourier_sum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [wpfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wpfs_pkg::CFG_W-1:0]    cfg_data,
  // point words
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [wpfs_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [wpfs_pkg::POS_W-1:0] in_pos_y,
  input  wire logic signed [wpfs_pkg::POS_W-1:0] in_pos_z,
  input  wire logic [wpfs_pkg::WGT_W-1:0]    in_point_weight,
  input  wire logic                          in_accepted,
  input  wire logic                          in_last_point,
  // result words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [wpfs_pkg::OUT_W-1:0]  out_real_part,
  output logic signed [wpfs_pkg::OUT_W-1:0]  out_imag_part
);
  import wpfs_pkg::*;

  // sequencer to datapath commands, datapath to sequencer status
  wpfs_cmd_t  cmd;
  wpfs_stat_t stat;

  wpfs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_accepted   (in_accepted),
    .in_last_point (in_last_point),
    .stat          (stat),
    .cmd           (cmd)
  );

  // datapath holds the wave vector, the sums and the output register
  wpfs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_point_weight (in_point_weight),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_real_part   (out_real_part),
    .out_imag_part   (out_imag_part)
  );

endmodule

`default_nettype wire

FILE: hdl/wpfs_ctrl.sv
// sequencer for the weighted point fourier sum
// depends on wpfs_pkg; drives the datapath through wpfs_cmd_t
`default_nettype none

module wpfs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_accepted,
  input  wire logic               in_last_point,
  input  wire wpfs_pkg::wpfs_stat_t stat,
  output wpfs_pkg::wpfs_cmd_t     cmd
);
  import wpfs_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DOT_X   = 4'd1;
  localparam logic [3:0] S_DOT_Y   = 4'd2;
  localparam logic [3:0] S_DOT_Z   = 4'd3;
  localparam logic [3:0] S_DOT_SUM = 4'd4;
  localparam logic [3:0] S_CORDIC  = 4'd5;
  localparam logic [3:0] S_TFIX    = 4'd6;
  localparam logic [3:0] S_WMUL_C  = 4'd7;
  localparam logic [3:0] S_WMUL_S  = 4'd8;
  localparam logic [3:0] S_ADD_S   = 4'd9;
  localparam logic [3:0] S_NC_HI   = 4'd10;
  localparam logic [3:0] S_NC_LO   = 4'd11;
  localparam logic [3:0] S_NS_HI   = 4'd12;
  localparam logic [3:0] S_NS_LO   = 4'd13;
  localparam logic [3:0] S_NFIN    = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(TRIG_BITS - 1);

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              last_r, last_nxt;
  logic              accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.iter  = iter_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = accept;
        if (accept) begin
          last_nxt = in_last_point;
          if (in_accepted) begin
            state_nxt = S_DOT_X;
          end else if (in_last_point) begin
            state_nxt = S_NC_HI;
          end
        end
      end
      S_DOT_X: begin
        cmd.mul_sel = MUL_X;
        state_nxt   = S_DOT_Y;
      end
      S_DOT_Y: begin
        cmd.mul_sel    = MUL_Y;
        cmd.phase_load = 1'b1;
        state_nxt      = S_DOT_Z;
      end
      S_DOT_Z: begin
        cmd.mul_sel   = MUL_Z;
        cmd.phase_add = 1'b1;
        state_nxt     = S_DOT_SUM;
      end
      S_DOT_SUM: begin
        // last partial product folds straight into the cordic start
        cmd.cordic_init = 1'b1;
        iter_nxt        = '0;
        state_nxt       = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        iter_nxt        = iter_r + 1'b1;
        if (iter_r == ITER_LAST) begin
          state_nxt = S_TFIX;
        end
      end
      S_TFIX: begin
        cmd.trig_fix = 1'b1;
        state_nxt    = S_WMUL_C;
      end
      S_WMUL_C: begin
        cmd.mul_sel = MUL_WC;
        state_nxt   = S_WMUL_S;
      end
      S_WMUL_S: begin
        cmd.mul_sel = MUL_WS;
        cmd.acc_cos = 1'b1;
        state_nxt   = S_ADD_S;
      end
      S_ADD_S: begin
        cmd.acc_sin = 1'b1;
        state_nxt   = last_r ? S_NC_HI : S_IDLE;
      end
      S_NC_HI: begin
        cmd.mul_sel = MUL_CHI;
        state_nxt   = S_NC_LO;
      end
      S_NC_LO: begin
        cmd.mul_sel = MUL_CLO;
        cmd.hold_hi = 1'b1;
        state_nxt   = S_NS_HI;
      end
      S_NS_HI: begin
        cmd.mul_sel = MUL_SHI;
        cmd.re_set  = 1'b1;
        state_nxt   = S_NS_LO;
      end
      S_NS_LO: begin
        cmd.mul_sel = MUL_SLO;
        cmd.hold_hi = 1'b1;
        state_nxt   = S_NFIN;
      end
      S_NFIN: begin
        cmd.im_set = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      last_r  <= last_nxt;
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output word still held");

  a_cos_then_sin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_cos |=> cmd.acc_sin)
    else $error("sine accumulate did not follow cosine accumulate");

  a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TFIX) |-> ($past(state_r) == S_CORDIC && $past(iter_r) == ITER_LAST))
    else $error("cordic left before all iterations ran");

  a_norm_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_S && last_r) |=> (state_r == S_NC_HI))
    else $error("last point did not start normalization");

endmodule

`default_nettype wire

FILE: hdl/wpfs_datapath.sv
// datapath: config registers, shared multiplier, phase, cordic,
// accumulators, normalization and output register; depends on wpfs_pkg
`default_nettype none

module wpfs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [wpfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wpfs_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic signed [wpfs_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [wpfs_pkg::POS_W-1:0] in_pos_y,
  input  wire logic signed [wpfs_pkg::POS_W-1:0] in_pos_z,
  input  wire logic [wpfs_pkg::WGT_W-1:0]    in_point_weight,
  input  wire wpfs_pkg::wpfs_cmd_t           cmd,
  output wpfs_pkg::wpfs_stat_t               stat,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [wpfs_pkg::OUT_W-1:0]  out_real_part,
  output logic signed [wpfs_pkg::OUT_W-1:0]  out_imag_part
);
  import wpfs_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam int RW    = 50;
  localparam int SHL   = (TRIG_BITS < 16) ? 16 - TRIG_BITS : 0;
  localparam int SHR   = (TRIG_BITS > 16) ? TRIG_BITS - 16 : 0;

  localparam logic signed [XW-1:0] X_INIT   = XW'(CORDIC_X0);
  localparam logic signed [XW-1:0] TRIG_MAX = XW'((64'd1 << (TRIG_BITS - 1)) - 64'd1);
  localparam logic signed [XW-1:0] TRIG_MIN = -TRIG_MAX - XW'(1);
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    SUM_W'((65'd1 << (ACC_BITS - 1)) - 65'd1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);
  localparam logic [RW-1:0] OUT_MAX_U = RW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [RW-1:0] OUT_MIN_U = RW'(64'd1 << (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'(OUT_MAX_U);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX - OUT_W'(1);
  localparam logic [64:0] ROUND_HALF = 65'h8000;
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

  // config registers
  logic signed [CFG_W-1:0] wave_x_r, wave_y_r, wave_z_r;
  logic [CFG_W-1:0]        norm_r;

  // captured point
  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [WGT_W-1:0]        wgt_r;

  // multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;

  // phase and cordic
  logic [31:0]              phase_r, phase_sum, phase_rot;
  logic [1:0]               quad_r, quad_init;
  logic signed [XW-1:0]     x_r, y_r, dx, dy;
  logic signed [31:0]       z_r, z_init;
  logic [31:0]              atan_i;
  logic signed [XW-1:0]     c_raw, s_raw;
  logic signed [TRIG_BITS-1:0] cos_r, sin_r;

  // accumulators
  logic signed [ACC_BITS-1:0] cos_acc_r, sin_acc_r, acc_sel, acc_new;
  logic signed [PROD_W-1:0]   term;
  logic signed [SUM_W-1:0]    sum;

  // normalization
  logic [ACC_BITS-1:0]      cos_mag, sin_mag;
  logic [63:0]              cos_mag64, sin_mag64;
  logic [63:0]              hi_r;
  logic signed [OUT_W-1:0]  re_r, im_r, norm_res;
  logic                     norm_neg;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]  out_re_r, out_im_r;

  function automatic logic signed [OUT_W-1:0] norm_round(
    input logic        neg,
    input logic [63:0] p_hi,
    input logic [63:0] p_lo
  );
    logic [RW-1:0]          r;
    logic [64:0]            lo_rnd;
    logic signed [OUT_W-1:0] v;
    lo_rnd = 65'(p_lo) + ROUND_HALF;
    r = (RW'(p_hi[31:0]) << 16) + RW'(lo_rnd >> 16);
    if (p_hi[63:32] != 32'd0) begin
      v = neg ? OUT_MIN : OUT_MAX;
    end else if (neg) begin
      v = (r >= OUT_MIN_U) ? OUT_MIN : -OUT_W'(r);
    end else begin
      v = (r > OUT_MAX_U) ? OUT_MAX : OUT_W'(r);
    end
    return v;
  endfunction

  // magnitudes of the sums for normalization
  assign cos_mag   = cos_acc_r[ACC_BITS-1] ? ACC_BITS'(-cos_acc_r) : ACC_BITS'(cos_acc_r);
  assign sin_mag   = sin_acc_r[ACC_BITS-1] ? ACC_BITS'(-sin_acc_r) : ACC_BITS'(sin_acc_r);
  assign cos_mag64 = 64'(cos_mag);
  assign sin_mag64 = 64'(sin_mag);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_X: begin
        mul_a = MUL_W'(wave_x_r);
        mul_b = MUL_W'(pos_x_r);
      end
      MUL_Y: begin
        mul_a = MUL_W'(wave_y_r);
        mul_b = MUL_W'(pos_y_r);
      end
      MUL_Z: begin
        mul_a = MUL_W'(wave_z_r);
        mul_b = MUL_W'(pos_z_r);
      end
      MUL_WC: begin
        mul_a = MUL_W'(wgt_r);
        mul_b = MUL_W'(cos_r);
      end
      MUL_WS: begin
        mul_a = MUL_W'(wgt_r);
        mul_b = MUL_W'(sin_r);
      end
      MUL_CHI: begin
        mul_a = MUL_W'(cos_mag64[63:32]);
        mul_b = MUL_W'(norm_r);
      end
      MUL_CLO: begin
        mul_a = MUL_W'(cos_mag64[31:0]);
        mul_b = MUL_W'(norm_r);
      end
      MUL_SHI: begin
        mul_a = MUL_W'(sin_mag64[63:32]);
        mul_b = MUL_W'(norm_r);
      end
      MUL_SLO: begin
        mul_a = MUL_W'(sin_mag64[31:0]);
        mul_b = MUL_W'(norm_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // phase wraps modulo one turn; quadrant and residual for the cordic
  assign phase_sum = phase_r + prod_r[31:0];
  assign phase_rot = phase_sum + EIGHTH_TURN;
  assign quad_init = phase_rot[31:30];
  assign z_init    = $signed(phase_sum - {quad_init, 30'd0});

  assign dx     = y_r >>> cmd.iter;
  assign dy     = x_r >>> cmd.iter;
  assign atan_i = atan_turn(ATAN_IDX_W'(cmd.iter));

  always_comb begin
    unique case (quad_r)
      2'd0: begin
        c_raw = x_r;
        s_raw = y_r;
      end
      2'd1: begin
        c_raw = -y_r;
        s_raw = x_r;
      end
      2'd2: begin
        c_raw = -x_r;
        s_raw = -y_r;
      end
      default: begin
        c_raw = y_r;
        s_raw = -x_r;
      end
    endcase
  end

  // scaled weight term and saturating add
  assign term    = (prod_r <<< SHL) >>> SHR;
  assign acc_sel = cmd.acc_sin ? sin_acc_r : cos_acc_r;
  assign sum     = SUM_W'(acc_sel) + SUM_W'(term);
  always_comb begin
    if (sum > ACC_MAX) begin
      acc_new = ACC_BITS'(ACC_MAX);
    end else if (sum < ACC_MIN) begin
      acc_new = ACC_BITS'(ACC_MIN);
    end else begin
      acc_new = ACC_BITS'(sum);
    end
  end

  assign norm_neg = cmd.im_set ? sin_acc_r[ACC_BITS-1] : cos_acc_r[ACC_BITS-1];
  assign norm_res = norm_round(norm_neg, hi_r, prod_r[63:0]);

  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_x_r    <= '0;
      wave_y_r    <= '0;
      wave_z_r    <= '0;
      norm_r      <= NORM_RESET;
      cos_acc_r   <= '0;
      sin_acc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WAVE_X:     wave_x_r <= cfg_data;
          REG_WAVE_Y:     wave_y_r <= cfg_data;
          REG_WAVE_Z:     wave_z_r <= cfg_data;
          REG_NORM_SCALE: norm_r   <= cfg_data;
          default:        ;
        endcase
      end
      if (cmd.out_load) begin
        cos_acc_r <= '0;
        sin_acc_r <= '0;
      end else if (cmd.acc_cos) begin
        cos_acc_r <= acc_new;
      end else if (cmd.acc_sin) begin
        sin_acc_r <= acc_new;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load_in) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      wgt_r   <= in_point_weight;
    end
    if (cmd.phase_load) begin
      phase_r <= prod_r[31:0];
    end else if (cmd.phase_add) begin
      phase_r <= phase_sum;
    end
    if (cmd.cordic_init) begin
      quad_r <= quad_init;
      x_r    <= X_INIT;
      y_r    <= '0;
      z_r    <= z_init;
    end else if (cmd.cordic_step) begin
      if (!z_r[31]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - $signed(atan_i);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + $signed(atan_i);
      end
    end
    if (cmd.trig_fix) begin
      cos_r <= (c_raw > TRIG_MAX) ? TRIG_BITS'(TRIG_MAX) :
               (c_raw < TRIG_MIN) ? TRIG_BITS'(TRIG_MIN) : TRIG_BITS'(c_raw);
      sin_r <= (s_raw > TRIG_MAX) ? TRIG_BITS'(TRIG_MAX) :
               (s_raw < TRIG_MIN) ? TRIG_BITS'(TRIG_MIN) : TRIG_BITS'(s_raw);
    end
    if (cmd.hold_hi) begin
      hi_r <= prod_r[63:0];
    end
    if (cmd.re_set) begin
      re_r <= norm_res;
    end
    if (cmd.im_set) begin
      im_r <= norm_res;
    end
    if (cmd.out_load) begin
      out_re_r <= re_r;
      out_im_r <= im_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_real_part = out_re_r;
  assign out_imag_part = out_im_r;

endmodule

`default_nettype wire
